FILE: hw/rtl/first_fit_heap_allocator_macros.svh
// Assertion macros used by the allocator's checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

    localparam logic [31:0] HEAP_BASE_DEF    = 32'h0010_0000;
    localparam int          HEAP_BYTES_DEF   = 65536;
    localparam int          HEADER_BYTES_DEF = 12;

    localparam int REQ_W     = 17;
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = REQ_W + 1;
    localparam int STATUS_W  = 2;
    localparam int ROUND_ADD = 7;
    localparam int SPLIT_PAD = 8;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_OOM     = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_ROUND,
        ST_A_READ,
        ST_A_CHECK,
        ST_A_NEXT1,
        ST_A_NEXT2,
        ST_A_HDR,
        ST_A_ADDR,
        ST_A_SPLIT,
        ST_A_REM,
        ST_A_WR_NEW,
        ST_A_WR_CUR,
        ST_F_SUB1,
        ST_F_SUB2,
        ST_F_READ,
        ST_F_CHECK,
        ST_F_NX1,
        ST_F_NX2,
        ST_F_NREAD,
        ST_F_NCHK,
        ST_F_MERGE,
        ST_F_WR_NXT,
        ST_F_WR_CUR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] result_address;
        status_t           status;
    } rsp_t;

endpackage

FILE: hw/rtl/ffha_alu.sv
// Shared 32-bit add/subtract unit with an unsigned greater-or-equal flag on subtracts.
module ffha_alu (
    input  ffha_pkg::alu_op_t             op,
    input  logic [ffha_pkg::ADDR_W-1:0]   a,
    input  logic [ffha_pkg::ADDR_W-1:0]   b,
    output logic [ffha_pkg::ADDR_W-1:0]   res,
    output logic                          ge
);

    logic                        sub;
    logic [ffha_pkg::ADDR_W-1:0] b_eff;
    logic                        carry;

    assign sub   = (op == ffha_pkg::ALU_SUB);
    assign b_eff = sub ? ~b : b;

    // A subtract is a + ~b + 1; its carry out is set exactly when a >= b.
    assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + {{ffha_pkg::ADDR_W{1'b0}}, sub};
    assign ge = sub & carry;

endmodule

FILE: hw/rtl/ffha_store.sv
// Header store: one start mark, free mark and payload size per heap word.
module ffha_store #(
    parameter int DEPTH   = ffha_pkg::HEAP_BYTES_DEF / 4,
    parameter int IDX_W   = $clog2(DEPTH),
    parameter int BYTES_W = $clog2(ffha_pkg::HEAP_BYTES_DEF + 1)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic               wr_start,
    input  logic               wr_free,
    input  logic [BYTES_W-1:0] wr_bytes,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic               rd_start,
    output logic               rd_free,
    output logic [BYTES_W-1:0] rd_bytes
);

    logic [BYTES_W+1:0] mem [DEPTH];
    logic [BYTES_W+1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_start, wr_free, wr_bytes};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_start = rd_data_reg[BYTES_W+1];
    assign rd_free  = rd_data_reg[BYTES_W];
    assign rd_bytes = rd_data_reg[BYTES_W-1:0];

endmodule

FILE: hw/rtl/ffha_seq.sv
// Sequencer and working registers: clearing pass, block walk, split and merge.
module ffha_seq #(
    parameter logic [31:0] HEAP_BASE    = ffha_pkg::HEAP_BASE_DEF,
    parameter int          HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int          HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int          HEAP_WORDS   = HEAP_BYTES / 4,
    parameter int          IDX_W        = $clog2(HEAP_WORDS),
    parameter int          BYTES_W      = $clog2(HEAP_BYTES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffha_pkg::req_t                req,
    output logic                          req_ready,
    output ffha_pkg::rsp_t                rsp,
    input  logic                          rsp_ready,
    output ffha_pkg::alu_op_t             alu_op,
    output logic [ffha_pkg::ADDR_W-1:0]   alu_a,
    output logic [ffha_pkg::ADDR_W-1:0]   alu_b,
    input  logic [ffha_pkg::ADDR_W-1:0]   alu_res,
    input  logic                          alu_ge,
    output logic                          st_wr_en,
    output logic [IDX_W-1:0]              st_wr_addr,
    output logic                          st_wr_start,
    output logic                          st_wr_free,
    output logic [BYTES_W-1:0]            st_wr_bytes,
    output logic                          st_rd_en,
    output logic [IDX_W-1:0]              st_rd_addr,
    input  logic                          st_rd_start,
    input  logic                          st_rd_free,
    input  logic [BYTES_W-1:0]            st_rd_bytes
);

    localparam int OFF_W  = $clog2(HEAP_BYTES) + 2;
    localparam int AW     = ffha_pkg::ADDR_W;
    localparam int SIZE_W = ffha_pkg::SIZE_W;

    localparam logic [AW-1:0]      HDR_A     = AW'(HEADER_BYTES);
    localparam logic [AW-1:0]      HEAP_A    = AW'(HEAP_BYTES);
    localparam logic [AW-3:0]      WORDS_A   = (AW-2)'(HEAP_WORDS);
    localparam logic [OFF_W-1:0]   HEAP_O    = OFF_W'(HEAP_BYTES);
    localparam logic [OFF_W-3:0]   WORDS_O   = (OFF_W-2)'(HEAP_WORDS);
    localparam logic [BYTES_W-1:0] SPLIT_THR =
        BYTES_W'(HEADER_BYTES + ffha_pkg::SPLIT_PAD);
    localparam logic [BYTES_W-1:0] INIT_BYTES = BYTES_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(HEAP_WORDS - 1);

    ffha_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]       tmp_reg, tmp_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [OFF_W-1:0]    noff_reg, noff_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [BYTES_W-1:0]  diff_reg, diff_next;
    logic [BYTES_W-1:0]  rem_reg, rem_next;
    logic                split_reg, split_next;
    logic                merge_reg, merge_next;
    logic [AW-1:0]       addr_reg, addr_next;
    ffha_pkg::status_t   status_reg, status_next;

    logic                off_ok;
    logic                res_word_ok;
    logic                rel_bad;

    assign off_ok      = (off_reg < HEAP_O) && (off_reg[OFF_W-1:2] < WORDS_O);
    assign res_word_ok = (alu_res < HEAP_A) && (alu_res[AW-1:2] < WORDS_A);
    assign rel_bad     = (alu_res >= HEAP_A) || (alu_res[1:0] != 2'b00)
                         || (alu_res[AW-1:2] >= WORDS_A);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = ffha_pkg::ST_IDLE;
                end
            end
            ffha_pkg::ST_IDLE: begin
                if (req.valid) begin
                    if (req.op == ffha_pkg::OP_ALLOC) begin
                        state_next = ffha_pkg::ST_A_ROUND;
                    end else if (req.free_address == '0) begin
                        state_next = ffha_pkg::ST_RESP;
                    end else begin
                        state_next = ffha_pkg::ST_F_SUB1;
                    end
                end
            end
            ffha_pkg::ST_A_ROUND:  state_next = ffha_pkg::ST_A_READ;
            ffha_pkg::ST_A_READ: begin
                state_next = off_ok ? ffha_pkg::ST_A_CHECK : ffha_pkg::ST_RESP;
            end
            ffha_pkg::ST_A_CHECK: begin
                if (!st_rd_start) begin
                    state_next = ffha_pkg::ST_RESP;
                end else if (st_rd_free && alu_ge) begin
                    state_next = ffha_pkg::ST_A_HDR;
                end else begin
                    state_next = ffha_pkg::ST_A_NEXT1;
                end
            end
            ffha_pkg::ST_A_NEXT1:  state_next = ffha_pkg::ST_A_NEXT2;
            ffha_pkg::ST_A_NEXT2:  state_next = ffha_pkg::ST_A_READ;
            ffha_pkg::ST_A_HDR:    state_next = ffha_pkg::ST_A_ADDR;
            ffha_pkg::ST_A_ADDR: begin
                state_next = (diff_reg > SPLIT_THR) ? ffha_pkg::ST_A_SPLIT
                                                    : ffha_pkg::ST_A_WR_CUR;
            end
            ffha_pkg::ST_A_SPLIT: begin
                state_next = res_word_ok ? ffha_pkg::ST_A_REM : ffha_pkg::ST_A_WR_CUR;
            end
            ffha_pkg::ST_A_REM:    state_next = ffha_pkg::ST_A_WR_NEW;
            ffha_pkg::ST_A_WR_NEW: state_next = ffha_pkg::ST_A_WR_CUR;
            ffha_pkg::ST_A_WR_CUR: state_next = ffha_pkg::ST_RESP;
            ffha_pkg::ST_F_SUB1:   state_next = ffha_pkg::ST_F_SUB2;
            ffha_pkg::ST_F_SUB2: begin
                state_next = rel_bad ? ffha_pkg::ST_RESP : ffha_pkg::ST_F_READ;
            end
            ffha_pkg::ST_F_READ:   state_next = ffha_pkg::ST_F_CHECK;
            ffha_pkg::ST_F_CHECK: begin
                state_next = st_rd_start ? ffha_pkg::ST_F_NX1 : ffha_pkg::ST_RESP;
            end
            ffha_pkg::ST_F_NX1:    state_next = ffha_pkg::ST_F_NX2;
            ffha_pkg::ST_F_NX2: begin
                state_next = res_word_ok ? ffha_pkg::ST_F_NREAD : ffha_pkg::ST_F_WR_CUR;
            end
            ffha_pkg::ST_F_NREAD:  state_next = ffha_pkg::ST_F_NCHK;
            ffha_pkg::ST_F_NCHK: begin
                state_next = (st_rd_start && st_rd_free) ? ffha_pkg::ST_F_MERGE
                                                         : ffha_pkg::ST_F_WR_CUR;
            end
            ffha_pkg::ST_F_MERGE:  state_next = ffha_pkg::ST_F_WR_NXT;
            ffha_pkg::ST_F_WR_NXT: state_next = ffha_pkg::ST_F_WR_CUR;
            ffha_pkg::ST_F_WR_CUR: state_next = ffha_pkg::ST_RESP;
            ffha_pkg::ST_RESP: begin
                if (rsp_ready) begin
                    state_next = ffha_pkg::ST_IDLE;
                end
            end
            default:               state_next = ffha_pkg::ST_IDLE;
        endcase
    end

    // Outputs and working-register updates.
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        tmp_next     = tmp_reg;
        off_next     = off_reg;
        noff_next    = noff_reg;
        size_next    = size_reg;
        bytes_next   = bytes_reg;
        diff_next    = diff_reg;
        rem_next     = rem_reg;
        split_next   = split_reg;
        merge_next   = merge_reg;
        addr_next    = addr_reg;
        status_next  = status_reg;

        req_ready   = 1'b0;
        rsp         = '{valid: 1'b0, result_address: addr_reg, status: status_reg};
        alu_op      = ffha_pkg::ALU_ADD;
        alu_a       = '0;
        alu_b       = '0;
        st_wr_en    = 1'b0;
        st_wr_addr  = off_reg[IDX_W+1:2];
        st_wr_start = 1'b0;
        st_wr_free  = 1'b0;
        st_wr_bytes = '0;
        st_rd_en    = 1'b0;
        st_rd_addr  = off_reg[IDX_W+1:2];

        case (state_reg)
            ffha_pkg::ST_CLEAR: begin
                st_wr_en     = 1'b1;
                st_wr_addr   = clr_cnt_reg;
                st_wr_start  = (clr_cnt_reg == '0);
                st_wr_free   = (clr_cnt_reg == '0);
                st_wr_bytes  = (clr_cnt_reg == '0) ? INIT_BYTES : '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ffha_pkg::ST_IDLE: begin
                req_ready   = 1'b1;
                off_next    = '0;
                addr_next   = '0;
                status_next = ffha_pkg::STAT_DONE;
                if (req.op == ffha_pkg::OP_ALLOC) begin
                    tmp_next = AW'(req.request_size);
                end else begin
                    tmp_next = req.free_address;
                    if (req.free_address == '0) begin
                        status_next = ffha_pkg::STAT_IGNORED;
                    end
                end
            end
            ffha_pkg::ST_A_ROUND: begin
                alu_a     = tmp_reg;
                alu_b     = AW'(ffha_pkg::ROUND_ADD);
                size_next = alu_res[SIZE_W-1:0] & ~SIZE_W'(ffha_pkg::ROUND_ADD);
            end
            ffha_pkg::ST_A_READ: begin
                st_rd_en = 1'b1;
                if (!off_ok) begin
                    status_next = ffha_pkg::STAT_OOM;
                end
            end
            ffha_pkg::ST_A_CHECK: begin
                alu_op     = ffha_pkg::ALU_SUB;
                alu_a      = AW'(st_rd_bytes);
                alu_b      = AW'(size_reg);
                bytes_next = st_rd_bytes;
                diff_next  = alu_res[BYTES_W-1:0];
                if (!st_rd_start) begin
                    status_next = ffha_pkg::STAT_OOM;
                end
            end
            ffha_pkg::ST_A_NEXT1, ffha_pkg::ST_A_HDR, ffha_pkg::ST_F_NX1: begin
                alu_a    = AW'(off_reg);
                alu_b    = HDR_A;
                tmp_next = alu_res;
            end
            ffha_pkg::ST_A_NEXT2: begin
                alu_a    = tmp_reg;
                alu_b    = AW'(bytes_reg);
                off_next = alu_res[OFF_W-1:0];
            end
            ffha_pkg::ST_A_ADDR: begin
                alu_a      = HEAP_BASE;
                alu_b      = tmp_reg;
                addr_next  = alu_res;
                split_next = (diff_reg > SPLIT_THR);
            end
            ffha_pkg::ST_A_SPLIT: begin
                alu_a     = tmp_reg;
                alu_b     = AW'(size_reg);
                noff_next = alu_res[OFF_W-1:0];
                if (!res_word_ok) begin
                    split_next = 1'b0;
                end
            end
            ffha_pkg::ST_A_REM: begin
                alu_op   = ffha_pkg::ALU_SUB;
                alu_a    = AW'(diff_reg);
                alu_b    = HDR_A;
                rem_next = alu_res[BYTES_W-1:0];
            end
            ffha_pkg::ST_A_WR_NEW: begin
                st_wr_en    = 1'b1;
                st_wr_addr  = noff_reg[IDX_W+1:2];
                st_wr_start = 1'b1;
                st_wr_free  = 1'b1;
                st_wr_bytes = rem_reg;
            end
            ffha_pkg::ST_A_WR_CUR: begin
                // The chosen block stays a block but is now in use.
                st_wr_en    = 1'b1;
                st_wr_start = 1'b1;
                st_wr_free  = 1'b0;
                st_wr_bytes = split_reg ? BYTES_W'(size_reg) : bytes_reg;
            end
            ffha_pkg::ST_F_SUB1: begin
                alu_op   = ffha_pkg::ALU_SUB;
                alu_a    = tmp_reg;
                alu_b    = HDR_A;
                tmp_next = alu_res;
            end
            ffha_pkg::ST_F_SUB2: begin
                alu_op   = ffha_pkg::ALU_SUB;
                alu_a    = tmp_reg;
                alu_b    = HEAP_BASE;
                off_next = alu_res[OFF_W-1:0];
                if (rel_bad) begin
                    status_next = ffha_pkg::STAT_IGNORED;
                end
            end
            ffha_pkg::ST_F_READ: begin
                st_rd_en = 1'b1;
            end
            ffha_pkg::ST_F_CHECK: begin
                bytes_next = st_rd_bytes;
                merge_next = 1'b0;
                if (!st_rd_start) begin
                    status_next = ffha_pkg::STAT_IGNORED;
                end
            end
            ffha_pkg::ST_F_NX2: begin
                alu_a     = tmp_reg;
                alu_b     = AW'(bytes_reg);
                noff_next = alu_res[OFF_W-1:0];
            end
            ffha_pkg::ST_F_NREAD: begin
                st_rd_en   = 1'b1;
                st_rd_addr = noff_reg[IDX_W+1:2];
            end
            ffha_pkg::ST_F_NCHK: begin
                alu_a    = AW'(bytes_reg);
                alu_b    = AW'(st_rd_bytes);
                rem_next = alu_res[BYTES_W-1:0];
            end
            ffha_pkg::ST_F_MERGE: begin
                alu_a      = AW'(rem_reg);
                alu_b      = HDR_A;
                rem_next   = alu_res[BYTES_W-1:0];
                merge_next = 1'b1;
            end
            ffha_pkg::ST_F_WR_NXT: begin
                // The absorbed block's header disappears.
                st_wr_en   = 1'b1;
                st_wr_addr = noff_reg[IDX_W+1:2];
            end
            ffha_pkg::ST_F_WR_CUR: begin
                st_wr_en    = 1'b1;
                st_wr_start = 1'b1;
                st_wr_free  = 1'b1;
                st_wr_bytes = merge_reg ? rem_reg : bytes_reg;
            end
            ffha_pkg::ST_RESP: begin
                rsp.valid = 1'b1;
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffha_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        tmp_reg    <= tmp_next;
        off_reg    <= off_next;
        noff_reg   <= noff_next;
        size_reg   <= size_next;
        bytes_reg  <= bytes_next;
        diff_reg   <= diff_next;
        rem_reg    <= rem_next;
        split_reg  <= split_next;
        merge_reg  <= merge_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
    end

endmodule

FILE: hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: stream ports and result register.
//
// Each beat on the s_ channel is one request. s_tuser[0] selects the operation
// (0 allocate, 1 free); s_tdata carries request_size and free_address. Each
// request produces exactly one beat on the m_ channel with the payload address
// of the new block (0 when there is none) and a status: done, out of memory,
// or free ignored.
// Requests are handled one at a time; s_tready is high only while the
// sequencer is idle. An allocate walks the block list one header at a time
// and takes further steps when the chosen block is split, because every
// header is fetched through the one read port of the header store and every
// address sum goes through the one shared adder. The result passes through
// the RESP state and the output register before it reaches m_tvalid.
// After aresetn is released the block sweeps the header store once, one word
// per cycle over HEAP_BYTES / 4 words (16384 at the default size), leaving one
// free block that spans the heap; s_tready stays low until the sweep is done.
// A result held by a stalled receiver sits in the output register. The block
// still takes and processes the next request meanwhile, and only waits to
// hand over its own result until the register is free again.
module first_fit_heap_allocator #(
    parameter logic [31:0] HEAP_BASE    = ffha_pkg::HEAP_BASE_DEF,
    parameter int          HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int          HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // From bit 0 up: request_size[16:0], free_address[31:0], zero fill.
    input  logic [ffha_pkg::S_TDATA_W-1:0]   s_tdata,
    // Bit 0: op.
    input  logic [ffha_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0 up: result_address[31:0], status[1:0], zero fill.
    output logic [ffha_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int IDX_W      = $clog2(HEAP_WORDS);
    localparam int BYTES_W    = $clog2(HEAP_BYTES + 1);
    localparam int AW         = ffha_pkg::ADDR_W;
    localparam int RW         = ffha_pkg::REQ_W;
    localparam int PAD_W      = ffha_pkg::M_TDATA_W - AW - ffha_pkg::STATUS_W;

    ffha_pkg::req_t      req;
    ffha_pkg::rsp_t      rsp;
    logic                rsp_ready;

    ffha_pkg::alu_op_t   alu_op;
    logic [AW-1:0]       alu_a;
    logic [AW-1:0]       alu_b;
    logic [AW-1:0]       alu_res;
    logic                alu_ge;

    logic                st_wr_en;
    logic [IDX_W-1:0]    st_wr_addr;
    logic                st_wr_start;
    logic                st_wr_free;
    logic [BYTES_W-1:0]  st_wr_bytes;
    logic                st_rd_en;
    logic [IDX_W-1:0]    st_rd_addr;
    logic                st_rd_start;
    logic                st_rd_free;
    logic [BYTES_W-1:0]  st_rd_bytes;

    logic                            m_tvalid_reg;
    logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    // Unpack the request beat.
    assign req = '{
        valid:        s_tvalid,
        op:           ffha_pkg::op_t'(s_tuser[0]),
        request_size: s_tdata[RW-1:0],
        free_address: s_tdata[RW+AW-1:RW]
    };

    // The output register can take a new result when it is empty or being
    // drained in this cycle.
    assign rsp_ready = !m_tvalid_reg || m_tready;

    ffha_seq #(
        .HEAP_BASE    (HEAP_BASE),
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .HEAP_WORDS   (HEAP_WORDS),
        .IDX_W        (IDX_W),
        .BYTES_W      (BYTES_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .req_ready   (s_tready),
        .rsp         (rsp),
        .rsp_ready   (rsp_ready),
        .alu_op      (alu_op),
        .alu_a       (alu_a),
        .alu_b       (alu_b),
        .alu_res     (alu_res),
        .alu_ge      (alu_ge),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_start (st_wr_start),
        .st_wr_free  (st_wr_free),
        .st_wr_bytes (st_wr_bytes),
        .st_rd_en    (st_rd_en),
        .st_rd_addr  (st_rd_addr),
        .st_rd_start (st_rd_start),
        .st_rd_free  (st_rd_free),
        .st_rd_bytes (st_rd_bytes)
    );

    ffha_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    ffha_store #(
        .DEPTH   (HEAP_WORDS),
        .IDX_W   (IDX_W),
        .BYTES_W (BYTES_W)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (st_wr_en),
        .wr_addr  (st_wr_addr),
        .wr_start (st_wr_start),
        .wr_free  (st_wr_free),
        .wr_bytes (st_wr_bytes),
        .rd_en    (st_rd_en),
        .rd_addr  (st_rd_addr),
        .rd_start (st_rd_start),
        .rd_free  (st_rd_free),
        .rd_bytes (st_rd_bytes)
    );

    // Result register: filled when the sequencer presents a result and the
    // register is free, emptied when the receiver takes the beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rsp.valid && rsp_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp.valid && rsp_ready) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, rsp.status, rsp.result_address};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hw/rtl/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level.
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ffha_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic s_beat;
    logic stat_fail;

    assign s_beat    = s_tvalid && s_tready;
    assign stat_fail = (m_tdata[33:32] != ffha_pkg::STAT_DONE);

    // A stalled result beat keeps its payload.
    `FFHA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // Every request passes through further sequencer states, so the block is busy right after one.
    `FFHA_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_beat, !s_tready, "request accepted on two consecutive cycles")

    // A failed or ignored request never returns an address.
    `FFHA_ASSERT_NOW(a_fail_no_addr, aclk, aresetn, m_tvalid && stat_fail, m_tdata[31:0] == 32'd0, "address returned with a failing status")

    // The zero fill above the status stays clear.
    `FFHA_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[39:34] == 6'd0, "nonzero fill bits in result beat")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
